@@ rtl/chd_pkg.sv @@
// Shared types and constants for the cosine hill tessellator.
// Holds the quarter-wave cosine table builder and the divider request/response structs.
// No dependencies.
package chd_pkg;

  localparam int unsigned COORD_BITS  = 12;
  localparam int unsigned FRAC_BITS   = 4;
  localparam int unsigned OUT_W       = 16;
  localparam int unsigned SPAN_W      = COORD_BITS + FRAC_BITS;
  localparam int unsigned SW_W        = 7;
  localparam int unsigned SEG_W       = 6;
  localparam int unsigned COS_ENTRIES = 256;
  localparam int unsigned COS_IDX_W   = $clog2(COS_ENTRIES + 1);
  localparam int unsigned PH_W        = $clog2(2 * COS_ENTRIES) + 1;
  localparam int unsigned COS_W       = 16;
  localparam int unsigned W_W         = 17;
  localparam int unsigned MIX_W       = COORD_BITS + W_W + 2;
  localparam int unsigned YR_W        = COORD_BITS + 16 + FRAC_BITS + 1;
  localparam int unsigned DIV_NUM_W   = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned DIV_DEN_W   = 7;
  localparam int unsigned REM_W       = DIV_DEN_W + 1;

  localparam logic [SW_W-1:0] SW_RESET = SW_W'(5);
  localparam logic [SW_W-1:0] SW_MIN   = SW_W'(2);
  localparam logic [SW_W-1:0] SW_MAX   = SW_W'(64);
  localparam logic [W_W-1:0]  Q15_ONE  = W_W'(32768);
  localparam logic [63:0]     PI_Q30   = 64'd3373259426;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
    logic [DIV_DEN_W-1:0] rem;
  } div_rsp_t;

  typedef logic [COS_W-1:0] cos_rom_t [0:COS_ENTRIES];

  // cos(pi*k/(2N)) in Q15 from a 13-term Taylor series in Q30, evaluated at elaboration
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t           rom;
    logic [63:0]        theta;
    logic [63:0]        t2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    for (int k = 0; k <= int'(COS_ENTRIES); k++) begin
      theta = (64'(k) * PI_Q30) / (2 * COS_ENTRIES);
      t2    = (theta * theta) >> 30;
      term  = 64'd1 << 30;
      sum   = signed'(term);
      for (int n = 1; n <= 12; n++) begin
        term = ((term * t2) >> 30) / 64'((2 * n - 1) * (2 * n));
        if ((n & 1) != 0) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = (sum + 64'sd16384) >>> 15;
      if (r > 64'sd32768) begin
        r = 64'sd32768;
      end
      rom[k] = COS_W'(r);
    end
    return rom;
  endfunction

endpackage

@@ rtl/chd_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on chd_pkg for widths and the request/response structs.
module chd_div
  import chd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(DIV_NUM_W + 1);

  logic                 busy_q;
  logic                 done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_DEN_W-1:0] den_q;

  logic [DIV_DEN_W:0]   trial;
  logic                 fits;
  logic [DIV_DEN_W:0]   diff;

  assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift the dividend out of the top while quotient bits enter at the bottom
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.num;
      rem_q <= '0;
      den_q <= req_i.den;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
      rem_q <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

@@ rtl/cosine_hill_tessellator_top.sv @@
// Cosine hill tessellator: key points in, half-cosine curve points out.
// Before the first word: no divider pass with no rise in x, one when the rise is under one segment,
// three for a curve. Each curve point then runs the lookup / multiply / emit loop, and output
// stalls can hold the emit step. A new key point is taken only once the last curve point of the
// previous one has been emitted.
// Reset (rst_ni low, async): sequencer idle, no word pending, no previous point, width 5.
module cosine_hill_tessellator_top
  import chd_pkg::*;
#(
  parameter int unsigned MaxSegments = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: segment_width
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  // key point stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [11:0] key_x, [23:12] key_y
  input  logic        s_axis_tuser_i,   // [0] start_req
  // curve point stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [15:0] out_x, [31:16] out_y
  output logic        m_axis_tuser_o,   // [0] clamped
  output logic        m_axis_tlast_o    // last curve point of this key point
);

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV_H = 3'd1;  // dx / segment_width
  localparam logic [2:0] S_DIV_X = 3'd2;  // 2*span / 2h
  localparam logic [2:0] S_DIV_P = 3'd3;  // 4N / 2h
  localparam logic [2:0] S_LOOK  = 3'd4;  // cosine table read
  localparam logic [2:0] S_MUL   = 3'd5;  // height blend multiply
  localparam logic [2:0] S_EMIT  = 3'd6;  // load output word

  localparam cos_rom_t COS_ROM = build_cos_rom();

  logic [2:0] state_q, state_d;

  // configuration and persistent key point
  logic [SW_W-1:0]       sw_q;
  logic [SW_W-1:0]       sw_eff;
  logic [COORD_BITS-1:0] prev_x_q, prev_y_q;
  logic                  have_prev_q;

  // per-item working registers
  logic [COORD_BITS-1:0] p0x_q, p0y_q, cy_q, dx_q;
  logic [SEG_W-1:0]      h_q, j_q;
  logic                  clamp_q;
  logic [SPAN_W-1:0]     qsx_q, xq_q;
  logic [PH_W-1:0]       qsp_q, pq_q;
  logic [DIV_DEN_W-1:0]  rsx_q, rsp_q;
  logic [REM_W-1:0]      xr_q, pr_q;
  logic [COS_W-1:0]      cos_q;
  logic                  neg_q;
  logic signed [MIX_W-1:0] prod_q;

  // output register
  logic              out_valid_q;
  logic [OUT_W-1:0]  out_x_q, out_y_q;
  logic              out_clamp_q, out_last_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  chd_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // Input decode: pick the start point of this curve
  // ---------------------------------------------------------------------------
  logic                  in_acc;
  logic [COORD_BITS-1:0] cx, cy, p0x, p0y;
  logic                  first, need_div;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign cx       = s_axis_tdata_i[COORD_BITS-1:0];
  assign cy       = s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS];
  assign first    = s_axis_tuser_i || !have_prev_q;
  assign p0x      = first ? cx : prev_x_q;
  assign p0y      = first ? cy : prev_y_q;
  assign need_div = !first && (cx > p0x);

  // hold the register inside its meaningful range
  always_comb begin
    if (sw_q < SW_MIN) begin
      sw_eff = SW_MIN;
    end else if (sw_q > SW_MAX) begin
      sw_eff = SW_MAX;
    end else begin
      sw_eff = sw_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Segment count saturation and divider requests
  // ---------------------------------------------------------------------------
  logic             clamp_now;
  logic [SEG_W-1:0] h_sat;

  assign clamp_now = div_rsp.quo > DIV_NUM_W'(MaxSegments);
  assign h_sat     = clamp_now ? SEG_W'(MaxSegments) : div_rsp.quo[SEG_W-1:0];

  always_comb begin
    div_req = '0;
    case (state_q)
      S_IDLE: begin
        div_req.start = in_acc && need_div;
        div_req.num   = DIV_NUM_W'(cx - p0x);
        div_req.den   = DIV_DEN_W'(sw_eff);
      end
      S_DIV_H: begin
        div_req.start = div_rsp.done && (h_sat != '0);
        div_req.num   = {dx_q, {(FRAC_BITS + 1){1'b0}}};
        div_req.den   = {h_sat, 1'b0};
      end
      S_DIV_X: begin
        div_req.start = div_rsp.done;
        div_req.num   = DIV_NUM_W'(4 * COS_ENTRIES);
        div_req.den   = {h_q, 1'b0};
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic emit_go;
  logic at_last;

  assign emit_go = (state_q == S_EMIT) && (!out_valid_q || m_axis_tready_i);
  assign at_last = (j_q == h_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = need_div ? S_DIV_H : S_LOOK;
        end
      end
      S_DIV_H: begin
        if (div_rsp.done) begin
          state_d = (h_sat == '0) ? S_LOOK : S_DIV_X;
        end
      end
      S_DIV_X: begin
        if (div_rsp.done) begin
          state_d = S_DIV_P;
        end
      end
      S_DIV_P: begin
        if (div_rsp.done) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK:  state_d = S_MUL;
      S_MUL:   state_d = S_EMIT;
      S_EMIT: begin
        if (emit_go) begin
          state_d = at_last ? S_IDLE : S_LOOK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sw_q        <= SW_RESET;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        sw_q <= cfg_wdata_i;
      end
      // the new point becomes the previous one as soon as it is taken
      if (in_acc) begin
        prev_x_q    <= cx;
        prev_y_q    <= cy;
        have_prev_q <= 1'b1;
      end
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Incremental quotients: x offset = floor((2*j*span + h) / 2h) and
  // phase = floor((4N*j + h) / 2h), advanced by quotient/remainder steps
  // ---------------------------------------------------------------------------
  logic [REM_W-1:0]  two_h;
  logic [REM_W-1:0]  xsum, psum;
  logic              xwrap, pwrap;

  assign two_h = REM_W'({h_q, 1'b0});
  assign xsum  = xr_q + REM_W'(rsx_q);
  assign psum  = pr_q + REM_W'(rsp_q);
  assign xwrap = xsum >= two_h;
  assign pwrap = psum >= two_h;

  // fold the phase onto the quarter-wave table
  logic                 ph_neg;
  logic [COS_IDX_W-1:0] ph_idx;
  logic [PH_W-1:0]      ph_mirror;

  assign ph_neg    = pq_q > PH_W'(COS_ENTRIES);
  assign ph_mirror = PH_W'(2 * COS_ENTRIES) - pq_q;
  assign ph_idx    = ph_neg ? ph_mirror[COS_IDX_W-1:0] : pq_q[COS_IDX_W-1:0];

  // y = cy + (p0y - cy) * w / 65536, w = 32768 + c
  logic [W_W-1:0]             w;
  logic signed [COORD_BITS:0] ydiff;
  logic signed [W_W:0]        w_s;
  logic signed [MIX_W-1:0]    prod_d;

  assign w      = neg_q ? (Q15_ONE - W_W'(cos_q)) : (Q15_ONE + W_W'(cos_q));
  assign ydiff  = signed'({1'b0, p0y_q}) - signed'({1'b0, cy_q});
  assign w_s    = signed'({1'b0, w});
  assign prod_d = ydiff * w_s;

  logic signed [MIX_W-1:0] cy_sh;
  logic signed [MIX_W-1:0] mix;
  logic [YR_W-1:0]         y_round;
  logic [OUT_W-1:0]        x_out;

  assign cy_sh   = signed'(MIX_W'({cy_q, 16'b0}));
  assign mix     = cy_sh + prod_q;
  assign y_round = YR_W'({mix[COORD_BITS+15:0], {FRAC_BITS{1'b0}}}) + YR_W'(32768);
  assign x_out   = OUT_W'({p0x_q, {FRAC_BITS{1'b0}}}) + OUT_W'(xq_q);

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          p0x_q   <= p0x;
          p0y_q   <= p0y;
          cy_q    <= cy;
          dx_q    <= cx - p0x;
          h_q     <= '0;
          clamp_q <= 1'b0;
          j_q     <= '0;
          xq_q    <= '0;
          xr_q    <= '0;
          pq_q    <= '0;
          pr_q    <= '0;
        end
      end
      S_DIV_H: begin
        if (div_rsp.done) begin
          h_q     <= h_sat;
          clamp_q <= clamp_now;
        end
      end
      S_DIV_X: begin
        if (div_rsp.done) begin
          qsx_q <= div_rsp.quo[SPAN_W-1:0];
          rsx_q <= div_rsp.rem;
        end
      end
      S_DIV_P: begin
        if (div_rsp.done) begin
          qsp_q <= div_rsp.quo[PH_W-1:0];
          rsp_q <= div_rsp.rem;
          // start both remainders at h so every step rounds half up
          xr_q  <= REM_W'(h_q);
          pr_q  <= REM_W'(h_q);
        end
      end
      S_LOOK: begin
        cos_q <= COS_ROM[ph_idx];
        neg_q <= ph_neg;
      end
      S_MUL: begin
        prod_q <= prod_d;
      end
      S_EMIT: begin
        if (emit_go) begin
          out_x_q     <= x_out;
          out_y_q     <= y_round[16 +: OUT_W];
          out_clamp_q <= clamp_q;
          out_last_q  <= at_last;
          if (!at_last) begin
            j_q  <= j_q + SEG_W'(1);
            xq_q <= xq_q + qsx_q + SPAN_W'(xwrap);
            xr_q <= xwrap ? (xsum - two_h) : xsum;
            pq_q <= pq_q + qsp_q + PH_W'(pwrap);
            pr_q <= pwrap ? (psum - two_h) : psum;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_y_q, out_x_q};
  assign m_axis_tuser_o  = out_clamp_q;
  assign m_axis_tlast_o  = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK) |-> (pq_q <= PH_W'(2 * COS_ENTRIES)))
    else $error("curve phase ran past the half wave");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK && h_q != '0) |-> (xr_q < two_h && pr_q < two_h))
    else $error("incremental remainder left its range");

  a_lands_on_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && at_last && h_q != '0) |->
      (xq_q == {dx_q, {FRAC_BITS{1'b0}}} && pq_q == PH_W'(2 * COS_ENTRIES)))
    else $error("last curve point does not land on the new key point");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV_H || state_q == S_DIV_X || state_q == S_DIV_P))
    else $error("divider finished outside a division step");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for cosine_hill_tessellator_top: key points in, curve points out.
// Predicts every curve point with its own cosine table and keeps a queue of expected points.
// Depends on rtl/chd_pkg.sv, rtl/chd_div.sv and rtl/cosine_hill_tessellator_top.sv.
`timescale 1ns / 1ps

module testbench;

  // Predictor constants for the default build of the block
  localparam int unsigned COS_N    = 256;
  localparam int unsigned FRAC     = 4;
  localparam int unsigned SEGS_MAX = 63;
  localparam bit [63:0]   PI_Q30_C = 64'd3373259426;

  // Tolerate the slowest legal run several times over: every key point with 64 curve
  // points, the lookup / multiply / emit loop plus divider passes, heavy stalls on both sides.
  localparam longint unsigned RUN_LIMIT_NS = 64'd30_000_000;

  // Stall plans per phase: sender idle and receiver stall, in percent
  localparam int unsigned MODES = 4;
  localparam int unsigned SEND_IDLE_PCT [MODES] = '{0, 65, 0, 21};
  localparam int unsigned RECV_STALL_PCT[MODES] = '{0, 0, 65, 21};

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        clamped;
    logic        last;
  } curve_point_t;

  // Tracks the previous key point and width, expands each key point into its curve
  // points, and checks the output stream against them in order.
  class curve_tracker;
    bit [15:0]    cos_q15 [0:COS_N];
    bit [11:0]    prev_x;
    bit [11:0]    prev_y;
    bit           have_prev;
    bit [6:0]     seg_width;
    curve_point_t pending_points[$];
    int unsigned  mismatches;

    function new();
      bit [63:0] theta;
      bit [63:0] t2;
      bit [63:0] term;
      longint    acc;
      longint    r;
      for (int k = 0; k <= COS_N; k++) begin
        theta = (64'(k) * PI_Q30_C) / (2 * COS_N);
        t2    = (theta * theta) >> 30;
        term  = 64'd1 << 30;
        acc   = longint'(term);
        for (int n = 1; n <= 12; n++) begin
          term = ((term * t2) >> 30) / 64'((2 * n - 1) * (2 * n));
          if ((n % 2) == 1) begin
            acc = acc - longint'(term);
          end else begin
            acc = acc + longint'(term);
          end
        end
        if (acc < 0) begin
          acc = 0;
        end
        r = (acc + 16384) >>> 15;
        if (r > 32768) begin
          r = 32768;
        end
        cos_q15[k] = r[15:0];
      end
      seg_width  = 7'd5;
      prev_x     = '0;
      prev_y     = '0;
      have_prev  = 1'b0;
      mismatches = 0;
    endfunction

    function void set_width(bit [6:0] value);
      seg_width = value;
    endfunction

    // Expand one accepted key point into the points the block must emit
    function void take_key(bit start, bit [11:0] kx, bit [11:0] ky);
      bit              fresh;
      bit              clip;
      bit [11:0]       ax;
      bit [11:0]       ay;
      longint unsigned sw;
      longint unsigned h;
      longint unsigned span;
      longint unsigned phase;
      longint unsigned w;
      longint unsigned mix;
      longint unsigned px;
      longint unsigned py;
      longint          c;
      curve_point_t    pt;
      fresh = start || !have_prev;
      ax    = fresh ? kx : prev_x;
      ay    = fresh ? ky : prev_y;
      sw    = (seg_width < 7'd2) ? 2 : (seg_width > 7'd64) ? 64 : 64'(seg_width);
      h     = 0;
      clip  = 1'b0;
      if (!fresh && kx > ax) begin
        h = 64'(kx - ax) / sw;
        if (h > SEGS_MAX) begin
          h    = SEGS_MAX;
          clip = 1'b1;
        end
      end
      for (longint unsigned j = 0; j <= h; j++) begin
        if (h == 0) begin
          px = 64'(ax) << FRAC;
          py = 64'(ay) << FRAC;
        end else begin
          span  = 64'(kx - ax) << FRAC;
          phase = (4 * COS_N * j + h) / (2 * h);
          if (phase <= COS_N) begin
            c = longint'(cos_q15[phase]);
          end else begin
            c = -longint'(cos_q15[2 * COS_N - phase]);
          end
          w   = 64'(32768 + c);
          mix = 64'(ay) * w + 64'(ky) * (65536 - w);
          px  = (64'(ax) << FRAC) + (2 * j * span + h) / (2 * h);
          py  = ((mix << FRAC) + 32768) >> 16;
        end
        pt.x       = px[15:0];
        pt.y       = py[15:0];
        pt.clamped = clip;
        pt.last    = (j == h);
        pending_points = {pending_points, pt};
      end
      prev_x    = kx;
      prev_y    = ky;
      have_prev = 1'b1;
    endfunction

    function void flag(string what, curve_point_t want, curve_point_t got);
      if (mismatches < 10) begin
        $display("mismatch (%s): exp x=%h y=%h clamped=%b last=%b, got x=%h y=%h clamped=%b last=%b",
                 what, want.x, want.y, want.clamped, want.last,
                 got.x, got.y, got.clamped, got.last);
      end
      mismatches++;
    endfunction

    function void check_point(curve_point_t got);
      curve_point_t want;
      if (pending_points.size() == 0) begin
        flag("no point expected", '0, got);
      end else begin
        want = pending_points.pop_front();
        if (got.x !== want.x || got.y !== want.y ||
            got.clamped !== want.clamped || got.last !== want.last) begin
          flag("field differs", want, got);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [6:0]  cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;

  curve_tracker tracker = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hill_x         = 0;  // x of the last key point sent, for building hills

  cosine_hill_tessellator_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // [11:0] key_x, [23:12] key_y
    .s_axis_tuser_i  (s_axis_tuser_i),   // [0] start_req
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),   // [15:0] out_x, [31:16] out_y
    .m_axis_tuser_o  (m_axis_tuser_o),   // [0] clamped
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // 12 ns clock, rising edge at 6 ns
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver: redraw tready every falling edge, so stalls land on every emit phase
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every curve point word taken at a rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      tracker.check_point({m_axis_tdata_o[15:0], m_axis_tdata_o[31:16],
                           m_axis_tuser_o, m_axis_tlast_o});
    end
  end

  // Offer one key point word. Entered and left just after a falling edge; tvalid stays
  // high on return so back-to-back words need no gap.
  task automatic send_key(input bit start, input bit [11:0] kx, input bit [11:0] ky);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {ky, kx};
    s_axis_tuser_i  <= start;
    @(posedge clk_i);
    while (!s_axis_tready_o) begin
      @(posedge clk_i);
    end
    tracker.take_key(start, kx, ky);
    @(negedge clk_i);
  endtask

  // Hold the sender off until every expected curve point has come out
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (tracker.pending_points.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Write segment_width; only called with the block idle
  task automatic write_width(input bit [6:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.set_width(value);
  endtask

  // Mostly rising hills with random heights; some fresh hills and some noise words.
  // Small rises dominate so most key points stay short; a few saturate or span the range.
  task automatic run_hills(input int unsigned count, input int unsigned sw_eff);
    int unsigned pick;
    int unsigned dx;
    int unsigned nx;
    bit          st;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      st   = 1'b0;
      if (pick < 8) begin
        st = 1'b1;
        nx = $urandom_range(0, 1023);
      end else if (pick < 14) begin
        st = 1'($urandom_range(1));
        nx = $urandom_range(0, 4095);
      end else begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          dx = $urandom_range(0, sw_eff * 12);
        end else if (pick < 92) begin
          dx = $urandom_range(0, sw_eff * 66);
        end else begin
          dx = $urandom_range(0, 4095);
        end
        nx = hill_x + dx;
        if (nx > 4095) begin
          st = 1'b1;
          nx = $urandom_range(0, 511);
        end
      end
      hill_x = nx;
      send_key(st, 12'(nx), 12'($urandom_range(0, 4095)));
    end
  endtask

  initial begin
    bit [6:0]    width_plan [8];
    bit [6:0]    wv;
    int unsigned sw_eff;
    width_plan = '{7'd2, 7'd64, 7'd0, 7'd127, 7'd1, 7'd65, 7'd0, 7'd5};
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed words at the reset width of 5
    send_key(1'b0, 12'd100, 12'd200);    // first word after reset without start_req
    send_key(1'b0, 12'd100, 12'd4095);   // no rise in x
    send_key(1'b0, 12'd50, 12'd0);       // x falls back
    send_key(1'b0, 12'd53, 12'd10);      // rise below one segment
    send_key(1'b0, 12'd58, 12'd4095);    // exactly one segment
    send_key(1'b0, 12'd200, 12'd0);      // ordinary curve
    send_key(1'b1, 12'd0, 12'd0);        // start of a hill at the origin
    send_key(1'b0, 12'd4095, 12'd4095);  // full-range rise, saturated
    send_key(1'b0, 12'd4095, 12'd0);     // no rise at the right edge
    send_key(1'b1, 12'd4095, 12'd4095);  // start at the far corner
    send_key(1'b1, 12'd0, 12'd4095);
    send_key(1'b0, 12'd315, 12'd0);      // exactly the segment limit, not saturated
    send_key(1'b0, 12'd635, 12'd4095);   // one past the limit, saturated
    send_key(1'b0, 12'd955, 12'd4095);   // saturated and flat
    send_key(1'b0, 12'd1000, 12'd2048);
    send_key(1'b0, 12'd1004, 12'd1);
    drain();
    hill_x = 1004;

    // Random phases: new width each phase, stall plans rotating through all modes
    for (int p = 0; p < 8; p++) begin
      wv = (p == 6) ? 7'($urandom_range(3, 63)) : width_plan[p];
      write_width(wv);
      sw_eff         = (wv < 7'd2) ? 2 : (wv > 7'd64) ? 64 : int'(wv);
      send_idle_pct  = SEND_IDLE_PCT[p % MODES];
      recv_stall_pct = RECV_STALL_PCT[p % MODES];
      run_hills(56, sw_eff);
      drain();
    end

    // Let any stray word show up before judging
    repeat (20) @(negedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_points.size() == 0) begin
      $display("cosine_hill_tessellator_top test passed");
    end else begin
      $display("cosine_hill_tessellator_top test failed");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("cosine_hill_tessellator_top test failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/chd_pkg.sv
rtl/chd_div.sv
rtl/cosine_hill_tessellator_top.sv
test/testbench.sv
